>>> src/traffic_signal_phase_sequencer_core_macros.svh
// Assertion macros used by the checker file of the phase sequencer.
`ifndef TRAFFIC_SIGNAL_PHASE_SEQUENCER_CORE_MACROS_SVH
`define TRAFFIC_SIGNAL_PHASE_SEQUENCER_CORE_MACROS_SVH

// Checked on every rising edge of clk while out of reset.
`define TSPS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked on every rising edge of clk, reset included.
`define TSPS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/tsps_pkg.sv
// Types, codes and constants of the traffic signal phase sequencer.
`timescale 1ns / 1ps

package tsps_pkg;

    localparam int FLASH_HALF_PERIOD_MS = 500;
    localparam logic LAMP_POLARITY = 1'b0;
    localparam int MS_PER_S = 1000;
    localparam int TIME_W = 32;

    // Flash phase is tracked as step time modulo the full flash period.
    localparam int FLASH_PERIOD_MS = 2 * FLASH_HALF_PERIOD_MS;
    localparam int PHASE_W = $clog2(FLASH_PERIOD_MS);
    localparam logic [31:0] FLASH_RECIP = 32'(64'd4294967296 / 64'(FLASH_PERIOD_MS));
    localparam logic [PHASE_W-1:0] FLASH_SAT_PHASE =
        PHASE_W'(64'd4294967295 % 64'(FLASH_PERIOD_MS));
    localparam logic [PHASE_W:0] FLASH_PERIOD = (PHASE_W + 1)'(FLASH_PERIOD_MS);
    localparam logic [PHASE_W-1:0] FLASH_HALF = PHASE_W'(FLASH_HALF_PERIOD_MS);

    // Change request codes on the tick channel.
    localparam logic [1:0] REQ_KEEP = 2'd0;
    localparam logic [1:0] REQ_TO_RED = 2'd1;
    localparam logic [1:0] REQ_TO_GREEN = 2'd2;
    localparam logic [1:0] REQ_CANCEL = 2'd3;

    // Latched request codes.
    localparam logic [1:0] PEND_NONE = 2'd0;
    localparam logic [1:0] PEND_RED = 2'd1;
    localparam logic [1:0] PEND_GREEN = 2'd2;

    // Aspect table codes.
    localparam logic [1:0] ASPECT_OFF = 2'd0;
    localparam logic [1:0] ASPECT_ON = 2'd1;
    localparam logic [1:0] ASPECT_FLASH = 2'd2;

    typedef enum logic [2:0] {
        STEP_GREEN      = 3'd0,
        STEP_POST_GREEN = 3'd1,
        STEP_PRE_RED    = 3'd2,
        STEP_RED        = 3'd3,
        STEP_POST_RED   = 3'd4,
        STEP_PRE_GREEN  = 3'd5
    } tsps_step_t;

    typedef enum logic [2:0] {
        REG_MIN_GREEN        = 3'd0,
        REG_MIN_POST_GREEN   = 3'd1,
        REG_MIN_PRE_RED      = 3'd2,
        REG_MIN_POST_RED     = 3'd3,
        REG_MIN_PRE_GREEN    = 3'd4,
        REG_ASPECT_TABLE     = 3'd5,
        REG_LAMPS_ENABLED    = 3'd6,
        REG_DETECTOR_PRESENT = 3'd7
    } tsps_reg_idx_t;

    typedef struct packed {
        logic [15:0] elapsed_ms;
        logic        vehicle_detected;
        logic [1:0]  change_request;
    } tsps_tick_t;

    typedef struct packed {
        logic       red_drive;
        logic       amber_drive;
        logic       green_drive;
        logic       demand_lamp;
        logic [2:0] signal_step;
        logic       green_min_done;
        logic [1:0] pending_request;
    } tsps_result_t;

    typedef struct packed {
        logic [7:0]  min_green_s;
        logic [7:0]  min_post_green_s;
        logic [7:0]  min_pre_red_s;
        logic [7:0]  min_post_red_s;
        logic [7:0]  min_pre_green_s;
        logic [35:0] aspect_table;
        logic        lamps_enabled;
        logic        detector_present;
    } tsps_cfg_t;

    typedef struct packed {
        tsps_step_t          step;
        logic [1:0]          pending_change;
        logic [TIME_W-1:0]   green_time_ms;
        logic [TIME_W-1:0]   step_time_ms;
        logic                demand;
        logic [PHASE_W-1:0]  flash_phase;
    } tsps_state_t;

    localparam tsps_cfg_t CFG_RESET = '{
        min_green_s:      8'd7,
        min_post_green_s: 8'd0,
        min_pre_red_s:    8'd3,
        min_post_red_s:   8'd0,
        min_pre_green_s:  8'd2,
        aspect_table:     36'd0,
        lamps_enabled:    1'b0,
        detector_present: 1'b0
    };

    localparam tsps_state_t STATE_RESET = '{
        step:           STEP_RED,
        pending_change: PEND_NONE,
        green_time_ms:  '0,
        step_time_ms:   '0,
        demand:         1'b0,
        flash_phase:    '0
    };

endpackage

>>> src/tsps_step_logic.sv
// Next phase state and lamp drives for one tick transaction.
`timescale 1ns / 1ps

module tsps_step_logic (
    input  tsps_pkg::tsps_state_t               cur,
    input  tsps_pkg::tsps_cfg_t                 cfg,
    input  tsps_pkg::tsps_tick_t                tick,
    input  logic [tsps_pkg::PHASE_W-1:0]        ms_mod,
    output tsps_pkg::tsps_state_t               nxt,
    output tsps_pkg::tsps_result_t              res
);

    logic [tsps_pkg::TIME_W:0]    gt_sum;
    logic [tsps_pkg::TIME_W:0]    st_sum;
    logic [tsps_pkg::PHASE_W:0]   ph_sum;
    logic [tsps_pkg::TIME_W-1:0]  green_thr;
    logic [tsps_pkg::TIME_W-1:0]  thr_post_green;
    logic [tsps_pkg::TIME_W-1:0]  thr_pre_red;
    logic [tsps_pkg::TIME_W-1:0]  thr_post_red;
    logic [tsps_pkg::TIME_W-1:0]  thr_pre_green;
    logic [tsps_pkg::TIME_W-1:0]  step_thr;
    logic                         mid_step;
    tsps_pkg::tsps_step_t         step_adv;
    logic [5:0]                   aspect_grp;
    logic                         flash_on;

    function automatic logic [5:0] aspect_group(input logic [35:0] tbl,
                                                input tsps_pkg::tsps_step_t s);
        logic [5:0] grp;
        unique case (s)
            tsps_pkg::STEP_GREEN:      grp = tbl[5:0];
            tsps_pkg::STEP_POST_GREEN: grp = tbl[11:6];
            tsps_pkg::STEP_PRE_RED:    grp = tbl[17:12];
            tsps_pkg::STEP_RED:        grp = tbl[23:18];
            tsps_pkg::STEP_POST_RED:   grp = tbl[29:24];
            tsps_pkg::STEP_PRE_GREEN:  grp = tbl[35:30];
            default:                   grp = '0;
        endcase
        return grp;
    endfunction

    function automatic logic lamp_drive(input logic [1:0] code, input logic flash,
                                        input logic enabled);
        logic lit;
        case (code)
            tsps_pkg::ASPECT_ON:    lit = 1'b1;
            tsps_pkg::ASPECT_FLASH: lit = flash;
            default:                lit = 1'b0;
        endcase
        return enabled ? (lit ^ tsps_pkg::LAMP_POLARITY) : tsps_pkg::LAMP_POLARITY;
    endfunction

    // Thresholds in milliseconds; comparing against them replaces a divide by 1000.
    assign green_thr      = 32'(cfg.min_green_s) * 32'(tsps_pkg::MS_PER_S);
    assign thr_post_green = 32'(cfg.min_post_green_s) * 32'(tsps_pkg::MS_PER_S);
    assign thr_pre_red    = 32'(cfg.min_pre_red_s) * 32'(tsps_pkg::MS_PER_S);
    assign thr_post_red   = 32'(cfg.min_post_red_s) * 32'(tsps_pkg::MS_PER_S);
    assign thr_pre_green  = 32'(cfg.min_pre_green_s) * 32'(tsps_pkg::MS_PER_S);

    // Next state.
    always_comb
    begin
        gt_sum = 33'(cur.green_time_ms) + 33'(tick.elapsed_ms);
        st_sum = 33'(cur.step_time_ms) + 33'(tick.elapsed_ms);
        ph_sum = {1'b0, cur.flash_phase} + {1'b0, ms_mod};
        nxt = cur;

        // The detector is sampled against the step held before the tick.
        if (cur.step != tsps_pkg::STEP_GREEN && cfg.detector_present &&
            tick.vehicle_detected)
        begin
            nxt.demand = 1'b1;
        end

        case (tick.change_request) inside
            tsps_pkg::REQ_TO_RED, tsps_pkg::REQ_TO_GREEN:
                nxt.pending_change = tick.change_request;
            tsps_pkg::REQ_CANCEL:
                nxt.pending_change = tsps_pkg::PEND_NONE;
            default:
                nxt.pending_change = cur.pending_change;
        endcase

        if (cur.step == tsps_pkg::STEP_GREEN)
        begin
            nxt.green_time_ms = gt_sum[32] ? '1 : gt_sum[31:0];
            nxt.demand = 1'b0;
        end
        else
        begin
            nxt.green_time_ms = '0;
        end

        // Once the step time saturates, its flash phase is frozen as well.
        nxt.step_time_ms = st_sum[32] ? '1 : st_sum[31:0];
        if (st_sum[32])
        begin
            nxt.flash_phase = tsps_pkg::FLASH_SAT_PHASE;
        end
        else if (ph_sum >= tsps_pkg::FLASH_PERIOD)
        begin
            nxt.flash_phase = tsps_pkg::PHASE_W'(ph_sum - tsps_pkg::FLASH_PERIOD);
        end
        else
        begin
            nxt.flash_phase = ph_sum[tsps_pkg::PHASE_W-1:0];
        end

        if (cur.step == tsps_pkg::STEP_GREEN && nxt.pending_change == tsps_pkg::PEND_RED &&
            nxt.green_time_ms >= green_thr)
        begin
            nxt.step = tsps_pkg::STEP_POST_GREEN;
            nxt.pending_change = tsps_pkg::PEND_NONE;
            nxt.step_time_ms = '0;
            nxt.flash_phase = '0;
        end
        if (nxt.step == tsps_pkg::STEP_RED && nxt.pending_change == tsps_pkg::PEND_GREEN)
        begin
            nxt.step = tsps_pkg::STEP_POST_RED;
            nxt.pending_change = tsps_pkg::PEND_NONE;
            nxt.step_time_ms = '0;
            nxt.flash_phase = '0;
        end

        // An intermediate step entered on this tick may pass at once when its minimum is zero.
        unique case (nxt.step)
            tsps_pkg::STEP_POST_GREEN:
            begin
                mid_step = 1'b1;
                step_thr = thr_post_green;
                step_adv = tsps_pkg::STEP_PRE_RED;
            end
            tsps_pkg::STEP_PRE_RED:
            begin
                mid_step = 1'b1;
                step_thr = thr_pre_red;
                step_adv = tsps_pkg::STEP_RED;
            end
            tsps_pkg::STEP_POST_RED:
            begin
                mid_step = 1'b1;
                step_thr = thr_post_red;
                step_adv = tsps_pkg::STEP_PRE_GREEN;
            end
            tsps_pkg::STEP_PRE_GREEN:
            begin
                mid_step = 1'b1;
                step_thr = thr_pre_green;
                step_adv = tsps_pkg::STEP_GREEN;
            end
            default:
            begin
                mid_step = 1'b0;
                step_thr = '0;
                step_adv = nxt.step;
            end
        endcase

        if (mid_step && nxt.step_time_ms >= step_thr)
        begin
            nxt.step = step_adv;
            nxt.step_time_ms = '0;
            nxt.flash_phase = '0;
        end
    end

    // Result fields.
    always_comb
    begin
        aspect_grp = aspect_group(cfg.aspect_table, nxt.step);
        flash_on = nxt.flash_phase < tsps_pkg::FLASH_HALF;
        res.red_drive = lamp_drive(aspect_grp[1:0], flash_on, cfg.lamps_enabled);
        res.amber_drive = lamp_drive(aspect_grp[3:2], flash_on, cfg.lamps_enabled);
        res.green_drive = lamp_drive(aspect_grp[5:4], flash_on, cfg.lamps_enabled);
        res.demand_lamp = lamp_drive(nxt.demand ? tsps_pkg::ASPECT_ON : tsps_pkg::ASPECT_OFF,
                                     flash_on, cfg.lamps_enabled);
        res.signal_step = nxt.step;
        res.green_min_done = nxt.green_time_ms >= green_thr;
        res.pending_request = nxt.pending_change;
    end

endmodule

>>> src/traffic_signal_phase_sequencer_core.sv
// Top level of the traffic signal phase sequencer: register port, pipeline and phase state.
`timescale 1ns / 1ps

// Channel     Handshake                      Payload                 Transaction
// ---------   ----------------------------   ---------------------   ----------------------
// tick        tick_valid / tick_ready        tick (tsps_tick_t)      one timer tick
// result      result_valid / result_ready    result (tsps_result_t)  lamp drives and status
// registers   psel / penable / pready        paddr, pwdata, prdata   one register access
//
// One tick transaction is accepted per cycle while tick_ready is high. Two stages reduce
// elapsed_ms modulo the flash period (a reciprocal multiply, then a multiply-subtract with
// one correction); the third stage updates the phase state as the transaction moves into
// the result register. Reset restores the register defaults and puts the phase at red with
// no request, no demand and cleared timers. When result_ready is low the stages fill one by
// one; tick_ready falls once s2, s3 and the result register are full, even with s1 empty.

module traffic_signal_phase_sequencer_core (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   tick_valid,
    output logic                   tick_ready,
    input  tsps_pkg::tsps_tick_t   tick,
    output logic                   result_valid,
    input  logic                   result_ready,
    output tsps_pkg::tsps_result_t result,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [5:0]             paddr,
    input  logic [63:0]            pwdata,
    output logic [63:0]            prdata,
    output logic                   pready
);

    // Register file.
    tsps_pkg::tsps_cfg_t      cfg_reg;
    tsps_pkg::tsps_cfg_t      cfg_next;
    tsps_pkg::tsps_reg_idx_t  reg_idx;
    logic                     reg_write;

    // Pipeline stages.
    logic                     s1_valid_reg;
    tsps_pkg::tsps_tick_t     s1_tick_reg;
    logic                     s2_valid_reg;
    tsps_pkg::tsps_tick_t     s2_tick_reg;
    logic [15:0]              s2_quot_reg;
    logic                     s3_valid_reg;
    tsps_pkg::tsps_tick_t     s3_tick_reg;
    logic [tsps_pkg::PHASE_W-1:0] s3_mod_reg;
    logic                     result_valid_reg;
    tsps_pkg::tsps_result_t   result_reg;

    logic                     ready_out;
    logic                     ready_s3;
    logic                     ready_s2;
    logic                     ready_s1;
    logic                     commit;

    logic [47:0]              recip_prod;
    logic [33:0]              quot_times_period;
    logic [33:0]              rem_raw;
    logic [tsps_pkg::PHASE_W-1:0] ms_mod;

    // Phase state.
    tsps_pkg::tsps_state_t    state_reg;
    tsps_pkg::tsps_state_t    state_next;
    tsps_pkg::tsps_result_t   result_next;

    // ------------------------------------------------------------------
    // Register port. Writes complete in the access phase; pready is tied high.
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign reg_idx = tsps_pkg::tsps_reg_idx_t'(paddr[5:3]);
    assign reg_write = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (reg_write)
        begin
            unique case (reg_idx)
                tsps_pkg::REG_MIN_GREEN:        cfg_next.min_green_s = pwdata[7:0];
                tsps_pkg::REG_MIN_POST_GREEN:   cfg_next.min_post_green_s = pwdata[7:0];
                tsps_pkg::REG_MIN_PRE_RED:      cfg_next.min_pre_red_s = pwdata[7:0];
                tsps_pkg::REG_MIN_POST_RED:     cfg_next.min_post_red_s = pwdata[7:0];
                tsps_pkg::REG_MIN_PRE_GREEN:    cfg_next.min_pre_green_s = pwdata[7:0];
                tsps_pkg::REG_ASPECT_TABLE:     cfg_next.aspect_table = pwdata[35:0];
                tsps_pkg::REG_LAMPS_ENABLED:    cfg_next.lamps_enabled = pwdata[0];
                tsps_pkg::REG_DETECTOR_PRESENT: cfg_next.detector_present = pwdata[0];
                default:                        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            tsps_pkg::REG_MIN_GREEN:        prdata = 64'(cfg_reg.min_green_s);
            tsps_pkg::REG_MIN_POST_GREEN:   prdata = 64'(cfg_reg.min_post_green_s);
            tsps_pkg::REG_MIN_PRE_RED:      prdata = 64'(cfg_reg.min_pre_red_s);
            tsps_pkg::REG_MIN_POST_RED:     prdata = 64'(cfg_reg.min_post_red_s);
            tsps_pkg::REG_MIN_PRE_GREEN:    prdata = 64'(cfg_reg.min_pre_green_s);
            tsps_pkg::REG_ASPECT_TABLE:     prdata = 64'(cfg_reg.aspect_table);
            tsps_pkg::REG_LAMPS_ENABLED:    prdata = 64'(cfg_reg.lamps_enabled);
            tsps_pkg::REG_DETECTOR_PRESENT: prdata = 64'(cfg_reg.detector_present);
            default:                        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= tsps_pkg::CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // ------------------------------------------------------------------
    // Flow control. Stages 2 and 3 and the result register take a new transaction when
    // empty or when their content moves on; stage 1 also waits while stage 2 is blocked,
    // so a stalled result holds tick_ready high until stages 2 and 3 are full.
    // ------------------------------------------------------------------
    assign ready_out  = !result_valid_reg || result_ready;
    assign ready_s3   = !s3_valid_reg || ready_out;
    assign ready_s2   = !s2_valid_reg || ready_s3;
    assign ready_s1   = !s2_valid_reg || ready_s2 ? (!s1_valid_reg || ready_s2) : 1'b0;
    assign tick_ready = ready_s1;
    assign commit     = s3_valid_reg && ready_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (ready_s1)
            begin
                s1_valid_reg <= tick_valid;
            end
            if (ready_s2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (ready_s3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (ready_out)
            begin
                result_valid_reg <= s3_valid_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // elapsed_ms modulo the flash period. The reciprocal quotient is low by at
    // most one, so a single conditional subtract finishes the remainder.
    // ------------------------------------------------------------------
    assign recip_prod = 48'(s1_tick_reg.elapsed_ms) * 48'(tsps_pkg::FLASH_RECIP);
    assign quot_times_period = 34'(s2_quot_reg) * 34'(tsps_pkg::FLASH_PERIOD_MS);
    assign rem_raw = 34'(s2_tick_reg.elapsed_ms) - quot_times_period;
    assign ms_mod = (rem_raw >= 34'(tsps_pkg::FLASH_PERIOD_MS))
                  ? tsps_pkg::PHASE_W'(rem_raw - 34'(tsps_pkg::FLASH_PERIOD_MS))
                  : tsps_pkg::PHASE_W'(rem_raw);

    always_ff @(posedge clk)
    begin
        if (ready_s1)
        begin
            s1_tick_reg <= tick;
        end
        if (ready_s2)
        begin
            s2_tick_reg <= s1_tick_reg;
            s2_quot_reg <= recip_prod[47:32];
        end
        if (ready_s3)
        begin
            s3_tick_reg <= s2_tick_reg;
            s3_mod_reg <= ms_mod;
        end
        if (commit)
        begin
            result_reg <= result_next;
        end
    end

    // ------------------------------------------------------------------
    // Phase state. It advances exactly once per transaction, as the transaction
    // moves from the last stage into the result register.
    // ------------------------------------------------------------------
    tsps_step_logic u_step_logic (
        .cur    (state_reg),
        .cfg    (cfg_reg),
        .tick   (s3_tick_reg),
        .ms_mod (s3_mod_reg),
        .nxt    (state_next),
        .res    (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tsps_pkg::STATE_RESET;
        end
        else if (commit)
        begin
            state_reg <= state_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result = result_reg;

endmodule

>>> src/tsps_checker.sv
// Port-level checker of the phase sequencer and its bind to the top level.
`timescale 1ns / 1ps
`include "traffic_signal_phase_sequencer_core_macros.svh"

module tsps_checker (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   result_valid,
    input logic                   result_ready,
    input tsps_pkg::tsps_result_t result
);

    logic       prev_valid_reg;
    logic [2:0] prev_step_reg;
    logic       step_ok;
    logic       left_hold;
    logic       stalled;
    logic       have_prev;
    logic       pend_clear;

    // Remember the step of the last delivered result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_valid_reg <= 1'b0;
            prev_step_reg <= 3'd0;
        end
        else if (result_valid && result_ready)
        begin
            prev_valid_reg <= 1'b1;
            prev_step_reg <= result.signal_step;
        end
    end

    // A tick advances the phase at most two steps from green or red, else at most one.
    always_comb
    begin
        case (prev_step_reg)
            tsps_pkg::STEP_GREEN:
                step_ok = result.signal_step == tsps_pkg::STEP_GREEN ||
                          result.signal_step == tsps_pkg::STEP_POST_GREEN ||
                          result.signal_step == tsps_pkg::STEP_PRE_RED;
            tsps_pkg::STEP_POST_GREEN:
                step_ok = result.signal_step == tsps_pkg::STEP_POST_GREEN ||
                          result.signal_step == tsps_pkg::STEP_PRE_RED;
            tsps_pkg::STEP_PRE_RED:
                step_ok = result.signal_step == tsps_pkg::STEP_PRE_RED ||
                          result.signal_step == tsps_pkg::STEP_RED;
            tsps_pkg::STEP_RED:
                step_ok = result.signal_step == tsps_pkg::STEP_RED ||
                          result.signal_step == tsps_pkg::STEP_POST_RED ||
                          result.signal_step == tsps_pkg::STEP_PRE_GREEN;
            tsps_pkg::STEP_POST_RED:
                step_ok = result.signal_step == tsps_pkg::STEP_POST_RED ||
                          result.signal_step == tsps_pkg::STEP_PRE_GREEN;
            tsps_pkg::STEP_PRE_GREEN:
                step_ok = result.signal_step == tsps_pkg::STEP_PRE_GREEN ||
                          result.signal_step == tsps_pkg::STEP_GREEN;
            default:
                step_ok = 1'b0;
        endcase
    end

    // Leaving green or red consumes the latched request.
    assign left_hold =
        (prev_step_reg == tsps_pkg::STEP_GREEN && result.signal_step != tsps_pkg::STEP_GREEN) ||
        (prev_step_reg == tsps_pkg::STEP_RED && result.signal_step != tsps_pkg::STEP_RED);

    assign stalled = result_valid && !result_ready;
    assign have_prev = result_valid && prev_valid_reg;
    assign pend_clear = result.pending_request == tsps_pkg::PEND_NONE;

    `TSPS_ASSERT(a_result_hold, stalled |=> result_valid && $stable(result), "result not held")
    `TSPS_ASSERT_ALWAYS(a_quiet_in_reset, !rst_n |-> !result_valid, "result valid in reset")
    `TSPS_ASSERT(a_step_order, have_prev |-> step_ok, "illegal phase step sequence")
    `TSPS_ASSERT(a_request_used, have_prev && left_hold |-> pend_clear, "request left pending")

endmodule

bind traffic_signal_phase_sequencer_core tsps_checker u_tsps_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);
